@@ src/jsu_pkg.sv @@
// Package for the JSON string unescaper: result kinds, phase codes, the result set
// that travels from the decoder to the output buffer, and the UTF-8 and hex helpers.
// No dependencies.
package jsu_pkg;

   // Result kinds as seen on the response channel.
   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_END  = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   // Decoder phase, one-hot.
   typedef enum logic [2:0] {
      PH_NORMAL = 3'b001,
      PH_ESCAPE = 3'b010,
      PH_HEX    = 3'b100
   } phase_type;

   localparam int MaxResults = 4;
   localparam int CountWidth = $clog2(MaxResults + 1);
   localparam int PosWidth   = $clog2(MaxResults);

   // Character codes used by the decoder.
   localparam logic [7:0] ChQuote     = 8'h22;
   localparam logic [7:0] ChBackslash = 8'h5C;
   localparam logic [7:0] ChSlash     = 8'h2F;
   localparam logic [7:0] ChLowerB    = 8'h62;
   localparam logic [7:0] ChLowerF    = 8'h66;
   localparam logic [7:0] ChLowerN    = 8'h6E;
   localparam logic [7:0] ChLowerR    = 8'h72;
   localparam logic [7:0] ChLowerT    = 8'h74;
   localparam logic [7:0] ChLowerU    = 8'h75;

   // One result entry.
   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
   } entry_type;

   // All results caused by one input byte.
   typedef struct packed {
      logic [CountWidth-1:0] count;
      entry_type [MaxResults-1:0] entry;
   } result_set_type;

   // UTF-8 encoding of a 16-bit code value: byte count and up to three bytes.
   typedef struct packed {
      logic [1:0] count;
      logic [2:0][7:0] bytes;
   } utf8_type;

   // Hex digit decode: flag and value.
   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic utf8_type utf8_encode(input logic [15:0] v);
      utf8_type u;
      u.bytes = '0;
      if (v < 16'h0080) begin
         u.count    = 2'd1;
         u.bytes[0] = v[7:0];
      end else if (v < 16'h0800) begin
         u.count    = 2'd2;
         u.bytes[0] = 8'hC0 | {3'b000, v[10:6]};
         u.bytes[1] = 8'h80 | {2'b00, v[5:0]};
      end else begin
         u.count    = 2'd3;
         u.bytes[0] = 8'hE0 | {4'b0000, v[15:12]};
         u.bytes[1] = 8'h80 | {2'b00, v[11:6]};
         u.bytes[2] = 8'h80 | {2'b00, v[5:0]};
      end
      return u;
   endfunction

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         h.value = c[3:0] + 4'd9;
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

@@ src/jsu_decode.sv @@
// Decoder for the JSON string unescaper: phase, hex count and code value registers
// and the logic that turns one input byte into its result set. Uses jsu_pkg.
module jsu_decode
   import jsu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     in_byte,
   output result_set_type result_set
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_value_ff, code_value_in;

   hex_type     hex;
   logic [15:0] code_shifted;
   utf8_type    utf8;
   logic [1:0]  prefix_count;
   logic        tail_valid;
   entry_type   tail;

   assign hex          = hex_decode(in_byte);
   assign code_shifted = {code_value_ff[11:0], hex.value};

   // Work out the UTF-8 prefix and the single tail result for this byte.
   always_comb begin
      phase_in      = phase_ff;
      hex_count_in  = hex_count_ff;
      code_value_in = code_value_ff;
      utf8          = utf8_encode(code_value_ff);
      prefix_count  = 2'd0;
      tail_valid    = 1'b0;
      tail.data     = 8'h00;
      tail.kind     = KIND_DATA;

      unique case (phase_ff)
         PH_ESCAPE: begin
            phase_in   = PH_NORMAL;
            tail_valid = 1'b1;
            case (in_byte)
               ChQuote, ChBackslash, ChSlash: tail.data = in_byte;
               ChLowerB: tail.data = 8'h08;
               ChLowerF: tail.data = 8'h0C;
               ChLowerN: tail.data = 8'h0A;
               ChLowerR: tail.data = 8'h0D;
               ChLowerT: tail.data = 8'h09;
               ChLowerU: begin
                  phase_in      = PH_HEX;
                  hex_count_in  = 2'd0;
                  code_value_in = 16'h0000;
                  tail_valid    = 1'b0;
               end
               default: tail.kind = KIND_ERR;
            endcase
         end
         PH_HEX: begin
            if (hex.ok) begin
               code_value_in = code_shifted;
               if (hex_count_ff == 2'd3) begin
                  utf8         = utf8_encode(code_shifted);
                  prefix_count = utf8.count;
                  phase_in     = PH_NORMAL;
                  hex_count_in = 2'd0;
               end else begin
                  hex_count_in = hex_count_ff + 2'd1;
               end
            end else begin
               // Short sequence: flush the value so far, then treat the byte as plain.
               prefix_count = utf8.count;
               hex_count_in = 2'd0;
               phase_in     = PH_NORMAL;
               if (in_byte == ChQuote) begin
                  tail_valid = 1'b1;
                  tail.kind  = KIND_END;
               end else if (in_byte == ChBackslash) begin
                  phase_in = PH_ESCAPE;
               end else begin
                  tail_valid = 1'b1;
                  tail.data  = in_byte;
               end
            end
         end
         default: begin
            phase_in = PH_NORMAL;
            if (in_byte == ChQuote) begin
               tail_valid = 1'b1;
               tail.kind  = KIND_END;
            end else if (in_byte == ChBackslash) begin
               phase_in = PH_ESCAPE;
            end else begin
               tail_valid = 1'b1;
               tail.data  = in_byte;
            end
         end
      endcase
   end

   // Place the prefix bytes first and the tail right after them.
   always_comb begin
      result_set.count = CountWidth'(prefix_count) + CountWidth'(tail_valid);
      for (int i = 0; i < MaxResults; i++) begin
         if (i < 3 && PosWidth'(i) < PosWidth'(prefix_count)) begin
            result_set.entry[i].data = utf8.bytes[i < 3 ? i : 0];
            result_set.entry[i].kind = KIND_DATA;
         end else begin
            result_set.entry[i] = tail;
         end
      end
   end

   // State moves only when a transaction is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_NORMAL;
         hex_count_ff  <= 2'd0;
         code_value_ff <= 16'h0000;
      end else if (accept) begin
         phase_ff      <= phase_in;
         hex_count_ff  <= hex_count_in;
         code_value_ff <= code_value_in;
      end
   end

endmodule

@@ src/jsu_burst.sv @@
// Result buffer for the JSON string unescaper: holds the result set of one input
// byte and hands it out one entry per transaction. Uses jsu_pkg.
module jsu_burst
   import jsu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  result_set_type result_set,
   output logic           can_load,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [7:0]     rsp_out_byte,
   output logic [1:0]     rsp_kind,
   output logic           rsp_last
);

   logic [CountWidth-1:0] remain_ff;
   logic [PosWidth-1:0]   pos_ff;
   entry_type             entry_ff [MaxResults];
   logic                  drain;

   assign rsp_valid    = (remain_ff != '0);
   assign drain        = rsp_valid && !rsp_stall;
   assign rsp_last     = (remain_ff == CountWidth'(1));
   assign rsp_out_byte = entry_ff[pos_ff].data;
   assign rsp_kind     = entry_ff[pos_ff].kind;

   // A new set may enter when the buffer is empty or the last entry of the current one is leaving.
   assign can_load = !rsp_valid || (rsp_last && drain);

   // Count and position of the entry on show.
   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         pos_ff    <= '0;
      end else if (load) begin
         remain_ff <= result_set.count;
         pos_ff    <= '0;
      end else if (drain) begin
         remain_ff <= remain_ff - CountWidth'(1);
         pos_ff    <= pos_ff + PosWidth'(1);
      end
   end

   // Payload entries.
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < MaxResults; i++) begin
            entry_ff[i] <= result_set.entry[i];
         end
      end
   end

endmodule

@@ src/json_string_unescape_utf8.sv @@
// Top level of the JSON string unescaper with UTF-8 output.
// Instantiates jsu_decode and jsu_burst; uses jsu_pkg.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid/req_stall  | req_in_byte
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_out_byte, rsp_kind, rsp_last
//
// One result leaves per cycle while rsp_stall is low. An input byte causes n results
// (0 to 4); the result buffer hands them out one a cycle unless stalled
// and takes the next byte in the cycle its final result is taken.
// Reset is synchronous and returns the decoder to the plain-character phase.
// A stall on the response side holds the buffer and, through it, the request side.
module json_string_unescape_utf8
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_last
);

   result_set_type result_set;
   logic           can_load;
   logic           accept;

   assign req_stall = !can_load;
   assign accept    = req_valid && can_load;

   jsu_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .result_set (result_set)
   );

   jsu_burst u_burst (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .result_set   (result_set),
      .can_load     (can_load),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_last     (rsp_last)
   );

endmodule

@@ src/jsu_checker.sv @@
// Port-level checker for the JSON string unescaper, bound to the top level.
// Uses jsu_pkg for the result kinds.
module jsu_checker
   import jsu_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_kind,
   input logic       rsp_last
);

   // A stalled result stays on show unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_kind)
         && $stable(rsp_last))
      else $error("stalled result changed");

   // Nothing is on show just after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown after reset");

   // No new byte is taken while a burst still has entries after the current one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("byte taken in the middle of a burst");

   // End and error markers carry a zero byte and close their burst.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_END || rsp_kind == KIND_ERR)
         |-> rsp_out_byte == 8'h00 && rsp_last)
      else $error("marker result malformed");

   // The spare kind code never appears.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind != 2'd3)
      else $error("undefined result kind");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_kind     (rsp_kind),
   .rsp_last     (rsp_last)
);

@@ bench/json_string_unescape_utf8_tb.sv @@
// Testbench for json_string_unescape_utf8: directed and random JSON string bodies,
// with each result checked against a behavioural decoder held in this file.
// Depends on jsu_pkg for the result kinds, decoder phases and character codes.
module json_string_unescape_utf8_tb;
   import jsu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 12;

   // Characters and control bytes that the decoder and the generator need.
   localparam logic [7:0] ChDigit0    = 8'h30;
   localparam logic [7:0] ChDigit9    = 8'h39;
   localparam logic [7:0] ChLowerA    = 8'h61;
   localparam logic [7:0] ChUpperA    = 8'h41;
   localparam logic [7:0] ChUpperF    = 8'h46;
   localparam logic [7:0] ChSpace     = 8'h20;
   localparam logic [7:0] ChTilde     = 8'h7E;
   localparam logic [7:0] CtlBackspace = 8'h08;
   localparam logic [7:0] CtlFormFeed = 8'h0C;
   localparam logic [7:0] CtlNewline  = 8'h0A;
   localparam logic [7:0] CtlReturn   = 8'h0D;
   localparam logic [7:0] CtlTab      = 8'h09;

   // One decoded result as it should appear on the response channel.
   typedef struct {
      logic [7:0] out_byte;
      kind_type   kind;
      logic       last;
   } decoded_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_kind;
   logic       rsp_last;

   // Decoder state as this bench sees it.
   phase_type   esc_phase   = PH_NORMAL;
   logic [1:0]  digit_count = '0;
   logic [15:0] code_acc    = '0;

   decoded_type decoded_q[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_sent    = 0;
   int fail_count    = 0;
   int data_seen     = 0;
   int end_seen      = 0;
   int err_seen      = 0;

   json_string_unescape_utf8 dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_last     (rsp_last)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Decoder prediction.
   // ---------------------------------------------------------------------

   function automatic void push_decoded(input logic [7:0] b, input kind_type k);
      decoded_type d;
      d.out_byte = b;
      d.kind     = k;
      d.last     = 1'b0;
      decoded_q.insert(decoded_q.size(), d);
   endfunction

   // Returns {is_hex, nibble}.
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= ChDigit0 && c <= ChDigit9) return {1'b1, c[3:0]};
      if ((c >= ChLowerA && c <= ChLowerF) || (c >= ChUpperA && c <= ChUpperF)) begin
         return {1'b1, 4'(c[3:0] + 4'd9)};
      end
      return 5'b0;
   endfunction

   // A code value leaves as one, two or three UTF-8 bytes; surrogates are not paired.
   function automatic void push_utf8(input logic [15:0] v);
      if (v < 16'h0080) begin
         push_decoded(v[7:0], KIND_DATA);
      end else if (v < 16'h0800) begin
         push_decoded({3'b110, v[10:6]}, KIND_DATA);
         push_decoded({2'b10, v[5:0]}, KIND_DATA);
      end else begin
         push_decoded({4'b1110, v[15:12]}, KIND_DATA);
         push_decoded({2'b10, v[11:6]}, KIND_DATA);
         push_decoded({2'b10, v[5:0]}, KIND_DATA);
      end
   endfunction

   function automatic void plain_char(input logic [7:0] c);
      esc_phase = PH_NORMAL;
      if (c == ChQuote) begin
         push_decoded(8'h00, KIND_END);
      end else if (c == ChBackslash) begin
         esc_phase = PH_ESCAPE;
      end else begin
         push_decoded(c, KIND_DATA);
      end
   endfunction

   function automatic void predict_char(input logic [7:0] c);
      int         first;
      logic [4:0] nib;
      first = decoded_q.size();
      case (esc_phase)
         PH_ESCAPE: begin
            esc_phase = PH_NORMAL;
            case (c)
               ChQuote, ChBackslash, ChSlash: push_decoded(c, KIND_DATA);
               ChLowerB: push_decoded(CtlBackspace, KIND_DATA);
               ChLowerF: push_decoded(CtlFormFeed, KIND_DATA);
               ChLowerN: push_decoded(CtlNewline, KIND_DATA);
               ChLowerR: push_decoded(CtlReturn, KIND_DATA);
               ChLowerT: push_decoded(CtlTab, KIND_DATA);
               ChLowerU: begin
                  esc_phase   = PH_HEX;
                  digit_count = '0;
                  code_acc    = '0;
               end
               default: push_decoded(8'h00, KIND_ERR);
            endcase
         end
         PH_HEX: begin
            nib = nibble_of(c);
            if (nib[4]) begin
               code_acc = {code_acc[11:0], nib[3:0]};
               if (digit_count == 2'd3) begin
                  push_utf8(code_acc);
                  esc_phase   = PH_NORMAL;
                  digit_count = '0;
               end else begin
                  digit_count = digit_count + 2'd1;
               end
            end else begin
               // A short sequence is flushed, then the byte is taken as ordinary text.
               push_utf8(code_acc);
               digit_count = '0;
               plain_char(c);
            end
         end
         default: plain_char(c);
      endcase
      if (decoded_q.size() > first) decoded_q[decoded_q.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Request side: one byte per transaction, with random idle cycles.
   // ---------------------------------------------------------------------

   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= c;
      do @(posedge clock); while (req_stall);
      predict_char(c);
      bytes_sent++;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return ChDigit0 + 8'(nib);
      return ($urandom_range(1) ? ChLowerA : ChUpperA) + 8'(nib) - 8'd10;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random stall and the result check.
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      decoded_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result: byte %h kind %0d last %b", $time,
                     rsp_out_byte, rsp_kind, rsp_last);
         end else begin
            want = decoded_q.pop_front();
            case (want.kind)
               KIND_END: end_seen++;
               KIND_ERR: err_seen++;
               default:  data_seen++;
            endcase
            if (rsp_out_byte !== want.out_byte || rsp_kind !== want.kind ||
                rsp_last !== want.last) begin
               fail_count++;
               $display("%0t: mismatch: expected byte %h kind %s last %b,", $time,
                        want.out_byte, want.kind.name(), want.last);
               $display("   got byte %h kind %0d last %b",
                        rsp_out_byte, rsp_kind, rsp_last);
            end
         end
      end
   end

   // The run is abandoned if no transaction moves on either side for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WatchdogLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
               WatchdogLimit, decoded_q.size());
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   // The lowest and highest ASCII byte values pass straight through as plain bytes.
   task automatic test_plain_bytes();
      send_char(8'h00);
      send_char(8'h7F);
   endtask

   // Every two-character escape.
   task automatic test_short_escapes();
      send_char(ChBackslash); send_char(ChQuote);
      send_char(ChBackslash); send_char(ChBackslash);
      send_char(ChBackslash); send_char(ChSlash);
      send_char(ChBackslash); send_char(ChLowerB);
      send_char(ChBackslash); send_char(ChLowerF);
      send_char(ChBackslash); send_char(ChLowerN);
      send_char(ChBackslash); send_char(ChLowerR);
      send_char(ChBackslash); send_char(ChLowerT);
   endtask

   // An unknown escape letter, here the top byte value.
   task automatic test_bad_escape();
      send_char(ChBackslash);
      send_char(8'hFF);
   endtask

   // A full surrogate value in four digits, then a three-digit sequence cut short by a
   // quote, which gives three UTF-8 bytes and the end marker from one byte.
   task automatic test_unicode_escapes();
      send_char(ChBackslash); send_char(ChLowerU);
      send_char(hex_char(4'hD)); send_char(hex_char(4'hF));
      send_char(hex_char(4'hF)); send_char(hex_char(4'hF));
      send_char(ChBackslash); send_char(ChLowerU);
      send_char(hex_char(4'hF)); send_char(hex_char(4'hF));
      send_char(hex_char(4'hF)); send_char(ChQuote);
   endtask

   // Mostly well-formed string bodies with random content, plus noise and broken escapes.
   task automatic test_random_strings(input int n_items);
      int          stop_at;
      int          sel;
      int          digits;
      logic [7:0]  c;
      logic [15:0] cp;
      stop_at = bytes_sent + n_items;
      while (bytes_sent < stop_at) begin
         sel = $urandom_range(99);
         if (sel < 30) begin
            do c = 8'($urandom_range(ChSpace, ChTilde));
            while (c == ChQuote || c == ChBackslash);
            send_char(c);
         end else if (sel < 40) begin
            send_char(8'($urandom_range(255)));
         end else if (sel < 55) begin
            send_char(ChBackslash);
            case ($urandom_range(7))
               0: send_char(ChQuote);
               1: send_char(ChBackslash);
               2: send_char(ChSlash);
               3: send_char(ChLowerB);
               4: send_char(ChLowerF);
               5: send_char(ChLowerN);
               6: send_char(ChLowerR);
               default: send_char(ChLowerT);
            endcase
         end else if (sel < 83) begin
            case ($urandom_range(3))
               0: cp = 16'($urandom_range(16'h007F));
               1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
               2: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
               default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            // Full sequences most of the time; short ones end on whatever follows.
            digits = (sel < 75) ? 4 : $urandom_range(3);
            send_char(ChBackslash);
            send_char(ChLowerU);
            for (int i = 0; i < digits; i++) send_char(hex_char(cp[15 - 4 * i -: 4]));
         end else if (sel < 90) begin
            send_char(ChBackslash);
            send_char(8'($urandom_range(255)));
         end else begin
            send_char(ChQuote);
         end
      end
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 10;
      recv_idle_pct = 46;
      test_plain_bytes();
      test_short_escapes();
      test_bad_escape();
      test_unicode_escapes();
      test_random_strings(145);

      send_idle_pct = 46;
      recv_idle_pct = 10;
      test_random_strings(145);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_strings(140);
      req_valid <= 1'b0;

      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d string bytes under three idling mixes; checked %0d data bytes,",
               bytes_sent, data_seen);
      $display("%0d end markers and %0d bad-escape errors.", end_seen, err_seen);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/jsu_pkg.sv
src/jsu_decode.sv
src/jsu_burst.sv
src/json_string_unescape_utf8.sv
src/jsu_checker.sv
bench/json_string_unescape_utf8_tb.sv
